// ----- rtl/core/sorted_key_set_table_unit_macros.svh -----
// Assertion macros for the sorted key set table unit.
// Used by the modules that carry assertions; expects clk and rst_n in scope.
`ifndef SORTED_KEY_SET_TABLE_UNIT_MACROS_SVH
`define SORTED_KEY_SET_TABLE_UNIT_MACROS_SVH

// Condition that holds at every clock edge out of reset
`define SKST_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define SKST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SKST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/skst_pkg.sv -----
// Types and codes shared by the sorted key set table unit.
// No dependencies.
`timescale 1ns / 1ps

package skst_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_DONE    = 2'd0,
        STS_PRESENT = 2'd1,
        STS_ABSENT  = 2'd2,
        STS_FULL    = 2'd3
    } status_t;

    // Register word index of compare_signed
    localparam logic REG_COMPARE_SIGNED = 1'b0;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] position;
        logic [6:0] entry_count;
    } rsp_t;

endpackage

// ----- rtl/core/skst_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module skst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/sorted_key_set_table_unit.sv -----
// Sorted key set table unit: top level with request sequencer and key store.
// Depends on skst_pkg, skst_ram and sorted_key_set_table_unit_macros.svh.
`timescale 1ns / 1ps

// Holds up to CAPACITY unique keys in ascending order in one RAM with a
// registered read. One request is worked at a time. A lookup runs a binary
// search, each probe a read of the middle key and a compare, then a final
// read and check of the key at the found slot, then hands over the response.
// Insert and remove move keys one slot at a time (one RAM read, one RAM
// write each); clear goes straight to FIN. The single RAM read port paces
// every step. A new request is taken while a response still waits on the
// output register. compare_signed selects unsigned or two's complement order
// and should be written only while the unit is idle.
module sorted_key_set_table_unit #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          req_valid,
    output logic          req_ready,
    input  skst_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output skst_pkg::rsp_t rsp
);

    import skst_pkg::*;
    `include "sorted_key_set_table_unit_macros.svh"

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [KEY_WIDTH-1:0] SIGN_BIT = {1'b1, {(KEY_WIDTH-1){1'b0}}};
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SRD  = 7'b0000010,
        ST_SCMP = 7'b0000100,
        ST_CCMP = 7'b0001000,
        ST_MRD  = 7'b0010000,
        ST_MWR  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [1:0]            act_reg, act_next;
    logic [KEY_WIDTH-1:0]  key_reg, key_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [CW-1:0]         mid_reg, mid_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         j_reg, j_next;
    logic [1:0]            status_reg, status_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;
    logic                  cmp_signed_reg, cmp_signed_next;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [KEY_WIDTH-1:0]  mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [KEY_WIDTH-1:0]  mem_rdata;

    logic [KEY_WIDTH-1:0]  rank_key, rank_mem;
    logic                  rsp_load;
    logic                  cfg_wr;
    logic [CW-1:0]         mid_calc;

    skst_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_keys (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign pready    = 1'b1;
    assign prdata    = {31'b0, cmp_signed_reg};
    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_COMPARE_SIGNED);
    assign cmp_signed_next = cfg_wr ? pwdata[0] : cmp_signed_reg;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Flip the sign bit so that unsigned compare gives the chosen order
    assign rank_key = cmp_signed_reg ? (key_reg ^ SIGN_BIT) : key_reg;
    assign rank_mem = cmp_signed_reg ? (mem_rdata ^ SIGN_BIT) : mem_rdata;
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        logic hit;
        state_next  = state_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        cnt_next    = cnt_reg;
        j_next      = j_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next    = rsp_reg;
        rsp_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = AW'(j_reg);
        mem_wdata   = mem_rdata;
        mem_raddr   = AW'(mid_calc);
        hit         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    act_next = req.action;
                    key_next = KEY_WIDTH'(req.key);
                    lo_next  = '0;
                    hi_next  = cnt_reg;
                    pos_next = '0;
                    status_next = STS_DONE;
                    if (req.action == ACT_CLEAR)
                    begin
                        cnt_next   = '0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SRD;
                    end
                end
            end
            ST_SRD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = ST_SCMP;
                end
                else if (lo_reg < cnt_reg)
                begin
                    mem_raddr  = AW'(lo_reg);
                    state_next = ST_CCMP;
                end
                else
                begin
                    state_next = ST_CCMP;
                end
            end
            ST_SCMP:
            begin
                if (rank_mem < rank_key)
                begin
                    lo_next = mid_reg + ONE;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = ST_SRD;
            end
            ST_CCMP:
            begin
                hit = (lo_reg < cnt_reg) && (rank_mem == rank_key);
                priority case (act_reg)
                    ACT_INSERT:
                    begin
                        if (hit)
                        begin
                            status_next = STS_PRESENT;
                            pos_next    = lo_reg;
                            state_next  = ST_FIN;
                        end
                        else if (cnt_reg == CAP)
                        begin
                            status_next = STS_FULL;
                            state_next  = ST_FIN;
                        end
                        else
                        begin
                            j_next     = cnt_reg;
                            state_next = ST_MRD;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (hit)
                        begin
                            j_next     = lo_reg;
                            state_next = ST_MRD;
                        end
                        else
                        begin
                            status_next = STS_ABSENT;
                            state_next  = ST_FIN;
                        end
                    end
                    default:
                    begin
                        if (hit)
                        begin
                            pos_next = lo_reg;
                        end
                        else
                        begin
                            status_next = STS_ABSENT;
                        end
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_MRD:
            begin
                if (act_reg == ACT_INSERT)
                begin
                    if (j_reg > lo_reg)
                    begin
                        mem_raddr  = AW'(j_reg - ONE);
                        state_next = ST_MWR;
                    end
                    else
                    begin
                        // drop the new key into the opened slot
                        mem_we     = 1'b1;
                        mem_waddr  = AW'(lo_reg);
                        mem_wdata  = key_reg;
                        cnt_next   = cnt_reg + ONE;
                        pos_next   = lo_reg;
                        state_next = ST_FIN;
                    end
                end
                else
                begin
                    if ((j_reg + ONE) < cnt_reg)
                    begin
                        mem_raddr  = AW'(j_reg + ONE);
                        state_next = ST_MWR;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - ONE;
                        pos_next   = lo_reg;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MWR:
            begin
                mem_we = 1'b1;
                j_next = (act_reg == ACT_INSERT) ? (j_reg - ONE) : (j_reg + ONE);
                state_next = ST_MRD;
            end
            ST_FIN:
            begin
                // hold the result until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load             = 1'b1;
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.position    = 6'(pos_reg);
                    rsp_next.entry_count = 7'(cnt_reg);
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            cmp_signed_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
            cmp_signed_reg <= cmp_signed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        j_reg      <= j_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        rsp_reg    <= rsp_next;
    end

    `SKST_ASSERT_ALWAYS(a_cnt_cap, cnt_reg <= CAP, "key count above capacity")
    `SKST_ASSERT_IMP(a_wr_range, mem_we, (CW'(mem_waddr) <= cnt_reg),
        "store write beyond held keys")
    `SKST_ASSERT_NEXT(a_busy, req_valid && req_ready, !req_ready,
        "request taken while busy")
    `SKST_ASSERT_IMP(a_no_overrun, rsp_load, !rsp_valid_reg || rsp_ready,
        "response overwritten before taken")

endmodule
